@@ rtl/core/bbu_pkg.sv @@
`default_nettype none

package bbu_pkg;

  // Default number of entries in each stack.
  localparam int unsigned DefaultDepth = 1024;

  // Request codes.
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_UNDO   = 2'd1,
    CMD_QLAST  = 2'd2,
    CMD_QBAL   = 2'd3
  } cmd_e;

  // Bracket kind code that names no bracket.
  localparam logic [1:0] KindInvalid = 2'd3;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic execute;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_out;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/bracket_balance_with_undo_unit.sv @@
// A query result is registered after the READ and EXEC states; EXEC waits while
// an older result is unaccepted. A request is taken as the last one completes;
// each needs the synchronous top-of-stack read, then the push or pop using it.
// Reset: asynchronous, active low; clears both stack depths and all control
// state. The stack memories are not cleared and need no clearing pass.
`default_nettype none

module bracket_balance_with_undo_unit #(
  parameter int unsigned DEPTH = bbu_pkg::DefaultDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [1:0] bracket_kind_i,
  input  wire logic       is_closing_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      last_kind_o,
  output logic            last_closing_o,
  output logic            history_empty_o,
  output logic            balanced_o
);
  import bbu_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing of each request.
  bbu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Stacks, counters and result register.
  bbu_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .command_i       (command_i),
    .bracket_kind_i  (bracket_kind_i),
    .is_closing_i    (is_closing_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .last_kind_o     (last_kind_o),
    .last_closing_o  (last_closing_o),
    .history_empty_o (history_empty_o),
    .balanced_o      (balanced_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/bbu_ctrl.sv @@
`default_nettype none

module bbu_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire bbu_pkg::dp_status_t status_i,
  output bbu_pkg::ctrl_cmd_t      cmd_o
);
  import bbu_pkg::*;

  state_e state_q, state_d;
  logic   exec_go;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. A request may be taken in the same cycle as the
  // previous one completes, so a new request goes straight from EXEC to READ.
  always_comb begin
    exec_go     = !status_i.needs_out || status_i.out_free;
    in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_EXEC) && exec_go);
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.read    = (state_q == ST_READ);
    cmd_o.execute = (state_q == ST_EXEC) && exec_go;
    state_d     = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_d = cmd_o.capture ? ST_READ : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/bbu_datapath.sv @@
`default_nettype none

module bbu_datapath #(
  parameter int unsigned DEPTH = bbu_pkg::DefaultDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         command_i,
  input  wire logic [1:0]         bracket_kind_i,
  input  wire logic               is_closing_i,
  input  wire bbu_pkg::ctrl_cmd_t cmd_i,
  output bbu_pkg::dp_status_t     status_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              last_kind_o,
  output logic                    last_closing_o,
  output logic                    history_empty_o,
  output logic                    balanced_o
);
  import bbu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CountFull = CW'(DEPTH);
  localparam logic [CW-1:0] CountOne  = CW'(1);

  // History entry: matched flag, closing flag, kind.
  logic [3:0] hist_mem [DEPTH];
  logic [2:0] unm_mem  [DEPTH];

  cmd_e          cmd_q;
  logic [1:0]    kind_q;
  logic          close_q;
  logic [CW-1:0] hcount_q, hcount_d;
  logic [CW-1:0] ucount_q, ucount_d;
  logic [3:0]    hist_rd_q;
  logic [2:0]    unm_rd_q;
  logic [CW-1:0] hist_top_idx, unm_top_idx;

  logic          hist_we, unm_we, matched;
  logic [2:0]    unm_wdata;
  logic          hist_full, hist_empty, unm_full, unm_empty, unm_top_match;

  logic          out_valid_q;
  logic [1:0]    res_kind_q;
  logic          res_closing_q, res_empty_q, res_bal_q;

  // Captured request fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= cmd_e'(command_i);
      kind_q  <= bracket_kind_i;
      close_q <= is_closing_i;
    end
  end

  assign hist_full  = (hcount_q == CountFull);
  assign hist_empty = (hcount_q == '0);
  assign unm_full   = (ucount_q == CountFull);
  assign unm_empty  = (ucount_q == '0);
  assign hist_top_idx = hcount_q - CountOne;
  assign unm_top_idx  = ucount_q - CountOne;

  // Top-of-stack reads; only used when the matching count is non-zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      hist_rd_q <= hist_mem[hist_top_idx[AW-1:0]];
      unm_rd_q  <= unm_mem[unm_top_idx[AW-1:0]];
    end
  end

  assign unm_top_match = !unm_empty && (unm_rd_q == {1'b0, kind_q});

  // Stack update for append and undo.
  always_comb begin
    hcount_d  = hcount_q;
    ucount_d  = ucount_q;
    hist_we   = 1'b0;
    unm_we    = 1'b0;
    unm_wdata = {close_q, kind_q};
    matched   = 1'b0;
    if (cmd_i.execute) begin
      unique case (cmd_q)
        CMD_APPEND: begin
          if ((kind_q != KindInvalid) && !hist_full) begin
            hist_we  = 1'b1;
            hcount_d = hcount_q + CountOne;
            if (close_q && unm_top_match) begin
              matched  = 1'b1;
              ucount_d = ucount_q - CountOne;
            end else if (!unm_full) begin
              unm_we   = 1'b1;
              ucount_d = ucount_q + CountOne;
            end
          end
        end
        CMD_UNDO: begin
          if (!hist_empty) begin
            hcount_d = hcount_q - CountOne;
            if (hist_rd_q[3] && hist_rd_q[2]) begin
              // Undoing a matched closer restores its opener.
              unm_wdata = {1'b0, hist_rd_q[1:0]};
              if (!unm_full) begin
                unm_we   = 1'b1;
                ucount_d = ucount_q + CountOne;
              end
            end else if (!unm_empty) begin
              ucount_d = ucount_q - CountOne;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stack memories.
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hcount_q[AW-1:0]] <= {matched, close_q, kind_q};
    if (unm_we)  unm_mem[ucount_q[AW-1:0]]  <= unm_wdata;
  end

  // Stack depth counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcount_q <= '0;
      ucount_q <= '0;
    end else begin
      hcount_q <= hcount_d;
      ucount_q <= ucount_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute && status_o.needs_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && status_o.needs_out) begin
      if (cmd_q == CMD_QLAST) begin
        res_kind_q    <= hist_empty ? 2'd0 : hist_rd_q[1:0];
        res_closing_q <= hist_empty ? 1'b0 : hist_rd_q[2];
        res_empty_q   <= hist_empty;
        res_bal_q     <= 1'b0;
      end else begin
        res_kind_q    <= 2'd0;
        res_closing_q <= 1'b0;
        res_empty_q   <= 1'b0;
        res_bal_q     <= unm_empty;
      end
    end
  end

  assign status_o.needs_out = (cmd_q == CMD_QLAST) || (cmd_q == CMD_QBAL);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign last_kind_o     = res_kind_q;
  assign last_closing_o  = res_closing_q;
  assign history_empty_o = res_empty_q;
  assign balanced_o      = res_bal_q;

endmodule

`default_nettype wire

@@ tb/tb_bracket_balance_with_undo_unit.sv @@
`default_nettype none

module tb_bracket_balance_with_undo_unit;

  import bbu_pkg::*;

  localparam int unsigned StackDepth = DefaultDepth;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned RandomRequests = 120;

  // One stack entry: the closing flag above the bracket kind.
  typedef struct packed {
    logic       closing;
    logic [1:0] kind;
  } bracket_t;

  // One predicted answer, laid out as the result ports.
  typedef struct packed {
    logic [1:0] last_kind;
    logic       last_closing;
    logic       history_empty;
    logic       balanced;
  } answer_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  cmd_e       command = CMD_QBAL;
  logic [1:0] bracket_kind = 2'd0;
  logic       is_closing = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] last_kind;
  logic       last_closing;
  logic       history_empty;
  logic       balanced;

  // Shadow copy of the block's two stacks.
  bracket_t    hist_stack [StackDepth];
  logic        hist_matched [StackDepth];
  int unsigned hist_depth = 0;
  bracket_t    open_stack [StackDepth];
  int unsigned open_depth = 0;

  answer_t     answer_q [$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;

  bracket_balance_with_undo_unit #(
    .DEPTH(StackDepth)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .bracket_kind_i (bracket_kind),
    .is_closing_i   (is_closing),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .last_kind_o    (last_kind),
    .last_closing_o (last_closing),
    .history_empty_o(history_empty),
    .balanced_o     (balanced)
  );

  always #2 clk = ~clk;

  // Applies one accepted request to the shadow stacks and queues any answer.
  function automatic void track_brackets(cmd_e cmd, logic [1:0] kind, logic closing);
    bracket_t ent;
    answer_t  ans;
    ans = '0;
    case (cmd)
      CMD_APPEND: begin
        if (kind != KindInvalid && hist_depth < StackDepth) begin
          ent = '{closing, kind};
          hist_matched[hist_depth] = 1'b0;
          if (closing && open_depth > 0 &&
              open_stack[open_depth - 1] == bracket_t'{1'b0, kind}) begin
            open_depth--;
            hist_matched[hist_depth] = 1'b1;
          end else begin
            open_stack[open_depth] = ent;
            open_depth++;
          end
          hist_stack[hist_depth] = ent;
          hist_depth++;
        end
      end
      CMD_UNDO: begin
        if (hist_depth > 0) begin
          hist_depth--;
          ent = hist_stack[hist_depth];
          // A closer that matched gives its opener back; anything else was pushed.
          if (ent.closing && hist_matched[hist_depth]) begin
            open_stack[open_depth] = '{1'b0, ent.kind};
            open_depth++;
          end else if (open_depth > 0) begin
            open_depth--;
          end
        end
      end
      CMD_QLAST: begin
        if (hist_depth == 0) begin
          ans.history_empty = 1'b1;
        end else begin
          ans.last_kind    = hist_stack[hist_depth - 1].kind;
          ans.last_closing = hist_stack[hist_depth - 1].closing;
        end
        answer_q.push_back(ans);
      end
      default: begin
        ans.balanced = (open_depth == 0);
        answer_q.push_back(ans);
      end
    endcase
  endfunction

  // Checks each result against the oldest answer, then tracks the accepted request.
  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("result with no request waiting for one");
        mismatches++;
      end else begin
        exp_ans = answer_q.pop_front();
        if (last_kind !== exp_ans.last_kind) begin
          $error("last_kind: expected %0d, actual %0d", exp_ans.last_kind, last_kind);
          mismatches++;
        end
        if (last_closing !== exp_ans.last_closing) begin
          $error("last_closing: expected %0d, actual %0d", exp_ans.last_closing,
                 last_closing);
          mismatches++;
        end
        if (history_empty !== exp_ans.history_empty) begin
          $error("history_empty: expected %0d, actual %0d", exp_ans.history_empty,
                 history_empty);
          mismatches++;
        end
        if (balanced !== exp_ans.balanced) begin
          $error("balanced: expected %0d, actual %0d", exp_ans.balanced, balanced);
          mismatches++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      track_brackets(command, bracket_kind, is_closing);
    end
  end

  // Result side: random stalls, a counted hold-off when one is requested, or always ready.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (recv_gaps) begin
      out_ready = ($urandom_range(99) >= 38);
    end else begin
      out_ready = 1'b1;
    end
  end

  // Ends the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offers one request, with random gaps in front, and waits until it is taken.
  task automatic send_request(cmd_e cmd, logic [1:0] kind, logic closing);
    @(negedge clk);
    while (send_gaps && $urandom_range(99) < 38) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    command      = cmd;
    bracket_kind = kind;
    is_closing   = closing;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Queries and undo on an empty history, and an append of an unknown kind.
  task automatic test_empty_history();
    send_request(CMD_QLAST, 2'd3, 1'b1);
    send_request(CMD_QBAL, 2'd0, 1'b0);
    send_request(CMD_UNDO, 2'd2, 1'b1);
    send_request(CMD_APPEND, KindInvalid, 1'b1);
    send_request(CMD_QLAST, 2'd1, 1'b0);
  endtask

  // Each kind opened and closed, then a mismatched closer and undo of a match.
  task automatic test_each_kind();
    for (int k = 0; k < 3; k++) begin
      send_request(CMD_APPEND, 2'(k), 1'b0);
      send_request(CMD_QLAST, 2'd0, 1'b0);
      send_request(CMD_APPEND, 2'(k), 1'b1);
      send_request(CMD_QLAST, 2'd0, 1'b0);
    end
    send_request(CMD_APPEND, 2'd0, 1'b0);
    send_request(CMD_APPEND, 2'd1, 1'b1);
    send_request(CMD_QBAL, 2'd0, 1'b0);
    send_request(CMD_UNDO, 2'd0, 1'b0);
    send_request(CMD_APPEND, 2'd0, 1'b1);
    send_request(CMD_QBAL, 2'd0, 1'b0);
    send_request(CMD_UNDO, 2'd0, 1'b0);
    send_request(CMD_QBAL, 2'd0, 1'b0);
    repeat (7) send_request(CMD_UNDO, 2'd0, 1'b0);
    send_request(CMD_QLAST, 2'd0, 1'b0);
  endtask

  // The result side holds off while queries keep coming, so the input stalls.
  task automatic test_result_hold_off();
    send_gaps = 1'b0;
    hold_left = 150;
    for (int i = 0; i < 40; i++) begin
      send_request((i % 2) ? CMD_QLAST : CMD_QBAL, 2'($urandom_range(3)),
                   1'($urandom_range(1)));
    end
    send_gaps = 1'b1;
  endtask

  // Mostly well-formed bracket runs with random content, the rest noise.
  task automatic test_random_mix();
    int unsigned first;
    int unsigned len;
    int unsigned appended;
    int unsigned roll;
    logic [1:0]  opens [$];
    logic [1:0]  k;
    cmd_e        cmd;
    logic        closing;
    first = requests_sent;
    while (requests_sent - first < RandomRequests) begin
      if (hist_depth > StackDepth - 64) begin
        repeat (64) send_request(CMD_UNDO, 2'($urandom_range(3)), 1'($urandom_range(1)));
      end
      if ($urandom_range(99) < 65) begin
        // A nested run that usually closes what it opens, with queries and undo mixed in.
        len = $urandom_range(2, 20);
        opens.delete();
        for (int i = 0; i < len; i++) begin
          if (opens.size() == 0 || (opens.size() < 10 && $urandom_range(1))) begin
            k = 2'($urandom_range(2));
            closing = 1'b0;
            opens.push_back(k);
          end else begin
            k = opens.pop_back();
            closing = 1'b1;
          end
          send_request(CMD_APPEND, k, closing);
          roll = $urandom_range(99);
          if (roll < 12) begin
            send_request(CMD_QLAST, 2'($urandom_range(3)), 1'($urandom_range(1)));
          end else if (roll < 20) begin
            send_request(CMD_QBAL, 2'($urandom_range(3)), 1'($urandom_range(1)));
          end else if (roll < 28) begin
            send_request(CMD_UNDO, 2'($urandom_range(3)), 1'($urandom_range(1)));
            send_request(CMD_QLAST, 2'($urandom_range(3)), 1'($urandom_range(1)));
            send_request(CMD_APPEND, k, closing);
          end
        end
        if ($urandom_range(9) < 7) begin
          while (opens.size() != 0) send_request(CMD_APPEND, opens.pop_back(), 1'b1);
        end
        send_request(CMD_QBAL, 2'($urandom_range(3)), 1'($urandom_range(1)));
      end else begin
        // Noise of any command and field value, then mostly undone again.
        len = $urandom_range(1, 8);
        appended = 0;
        for (int i = 0; i < len; i++) begin
          cmd = cmd_e'($urandom_range(3));
          k = 2'($urandom_range(3));
          send_request(cmd, k, 1'($urandom_range(1)));
          if (cmd == CMD_APPEND && k != KindInvalid) appended++;
        end
        if ($urandom_range(4) != 0) begin
          repeat (appended) send_request(CMD_UNDO, 2'($urandom_range(3)), 1'($urandom_range(1)));
        end
        send_request(CMD_QBAL, 2'($urandom_range(3)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Fills the history to the top, tries appends beyond it, then undoes part of it.
  task automatic test_full_history();
    int unsigned fill_count;
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    send_request(CMD_QBAL, 2'd0, 1'b0);
    fill_count = StackDepth - hist_depth;
    repeat (fill_count) begin
      send_request(CMD_APPEND, 2'($urandom_range(2)), 1'($urandom_range(1)));
    end
    send_request(CMD_QLAST, 2'd0, 1'b0);
    send_request(CMD_APPEND, 2'd2, 1'b1);
    send_request(CMD_APPEND, 2'd1, 1'b0);
    send_request(CMD_APPEND, 2'd0, 1'b1);
    send_request(CMD_QLAST, 2'd0, 1'b0);
    send_request(CMD_QBAL, 2'd0, 1'b0);
    repeat (8) send_request(CMD_UNDO, 2'd0, 1'b0);
    send_request(CMD_QLAST, 2'd0, 1'b0);
    send_request(CMD_QBAL, 2'd0, 1'b0);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_empty_history();
    test_each_kind();
    test_result_hold_off();
    test_random_mix();
    test_full_history();
    @(negedge clk);
    in_valid = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/bbu_pkg.sv
rtl/core/bbu_ctrl.sv
rtl/core/bbu_datapath.sv
rtl/core/bracket_balance_with_undo_unit.sv
tb/tb_bracket_balance_with_undo_unit.sv
